/* sv/cbf_pkg.sv */
// Shared types and constants for the counting Bloom filter.
// No dependencies; used by counting_bloom_filter and cbf_mod.
`default_nettype none

package cbf_pkg;

    // Commands carried by an input transaction
    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    // Configuration register indexes
    localparam int CFG_IDX_W      = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_LIMIT = 2'd1;

    localparam int TABLE_SIZE_W   = 11;
    localparam int FILL_LIMIT_W   = 8;
    localparam int CFG_DATA_W     = 11;
    localparam logic [TABLE_SIZE_W-1:0] TABLE_SIZE_RST = 11'd1024;
    localparam logic [FILL_LIMIT_W-1:0] FILL_LIMIT_RST = 8'd255;

    localparam int CMD_W          = 2;
    localparam int HASH_W         = 64;
    localparam int HALF_W         = 32;
    localparam int HIT_W          = 8;

    // Stream payload widths (rounded up to whole bytes)
    localparam int S_FIELDS_W     = CMD_W + HASH_W;
    localparam int S_TDATA_W      = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W     = 2 + HIT_W;
    localparam int M_TDATA_W      = ((M_FIELDS_W + 7) / 8) * 8;

    // Remainder unit: quotient bits retired per cycle
    localparam int MOD_STEPS      = 8;
    localparam int MOD_CYCLES     = HALF_W / MOD_STEPS;

endpackage

`default_nettype wire

/* sv/counting_bloom_filter.sv */
// Counting Bloom filter top level: sequencer, counter RAM and remainder unit.
// Depends on cbf_pkg, cbf_mod and cbf_ram.
`default_nettype none

// One transaction in, one result out. The two hash halves are reduced
// modulo the table size in use by a single shared remainder unit that
// retires 8 quotient bits per cycle, after which both
// counters are read and written back through the one RAM port pair, and
// then the add, remove or query result is loaded into the output
// register. A clear walks the whole counter RAM, one entry per cycle.
// After reset the same walk zeroes the RAM, during which s_tready stays
// low; configuration writes are taken at any time.
// The input is taken only while the block is idle; a finished result may
// sit in the output register while the next transaction is already running.
// A table_size of 0 or above NUM_COUNTERS selects NUM_COUNTERS.
module counting_bloom_filter #(
    parameter int NUM_COUNTERS = 1024,
    parameter int COUNTER_BITS = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration write port
    input  wire logic                             i_cfg_wen,
    input  wire logic [cbf_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  wire logic [cbf_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // input stream
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // [1:0] cmd, [65:2] key_hash, rest zero
    input  wire logic [cbf_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // result stream
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // [0] done_ok, [1] should_not_add, [9:2] hit_count, rest zero
    output logic      [cbf_pkg::M_TDATA_W-1:0]    o_m_tdata
);

    localparam int IDX_W  = $clog2(NUM_COUNTERS);
    localparam int SIZE_W = $clog2(NUM_COUNTERS + 1);
    localparam int CMP_W  = (COUNTER_BITS > cbf_pkg::HIT_W) ? COUNTER_BITS : cbf_pkg::HIT_W;
    localparam logic [IDX_W-1:0]        IDX_LAST = IDX_W'(NUM_COUNTERS - 1);
    localparam logic [COUNTER_BITS-1:0] CNT_MAX  = {COUNTER_BITS{1'b1}};
    localparam logic [CMP_W-1:0]        HIT_MAX  = CMP_W'({cbf_pkg::HIT_W{1'b1}});

    typedef enum logic [9:0] {
        S_CLR     = 10'b00_0000_0001,
        S_IDLE    = 10'b00_0000_0010,
        S_MOD_HI  = 10'b00_0000_0100,
        S_MOD_LO  = 10'b00_0000_1000,
        S_RD1     = 10'b00_0001_0000,
        S_RD2     = 10'b00_0010_0000,
        S_RD_WAIT = 10'b00_0100_0000,
        S_WR1     = 10'b00_1000_0000,
        S_WR2     = 10'b01_0000_0000,
        S_RESP    = 10'b10_0000_0000
    } t_state;

    t_state                              r_state, n_state;
    logic [cbf_pkg::TABLE_SIZE_W-1:0]    r_table_size;
    logic [cbf_pkg::FILL_LIMIT_W-1:0]    r_fill_limit;
    cbf_pkg::t_cmd                       r_cmd;
    logic [cbf_pkg::HALF_W-1:0]          r_hash_lo;
    logic [IDX_W-1:0]                    r_idx1, r_idx2;
    logic [COUNTER_BITS-1:0]             r_c1;
    logic [COUNTER_BITS-1:0]             r_new1, r_new2;
    logic                                r_wr;
    logic                                r_ok, r_sna;
    logic [cbf_pkg::HIT_W-1:0]           r_hit;
    logic [IDX_W-1:0]                    r_clr_addr;
    logic                                r_clr_cmd;
    logic                                r_m_tvalid;
    logic [cbf_pkg::M_TDATA_W-1:0]       r_m_tdata;

    cbf_pkg::t_cmd                       s_cmd;
    logic [cbf_pkg::HALF_W-1:0]          s_hash_hi, s_hash_lo;
    logic                                s_accept;
    logic                                out_load;
    logic                                size_ok;
    logic [SIZE_W-1:0]                   size_use;
    logic                                mod_start, mod_done;
    logic [cbf_pkg::HALF_W-1:0]          mod_dividend;
    logic [SIZE_W-1:0]                   mod_rem;
    logic                                ram_we;
    logic [IDX_W-1:0]                    ram_waddr, ram_raddr;
    logic [COUNTER_BITS-1:0]             ram_wdata, ram_rdata;
    logic                                idx_eq;

    // evaluation of the two fetched counters
    logic [COUNTER_BITS-1:0]             c1, c2;
    logic                                lt1, lt2, nz1, nz2, both;
    logic [COUNTER_BITS-1:0]             inc1, inc1b, inc2, dec1, dec1b, dec2;
    logic [CMP_W-1:0]                    hit_wide;
    logic                                ev_ok, ev_sna, ev_wr;
    logic [cbf_pkg::HIT_W-1:0]           ev_hit;
    logic [COUNTER_BITS-1:0]             ev_new1, ev_new2;

    // input field unpacking
    assign s_cmd     = cbf_pkg::t_cmd'(i_s_tdata[cbf_pkg::CMD_W-1:0]);
    assign s_hash_lo = i_s_tdata[cbf_pkg::CMD_W +: cbf_pkg::HALF_W];
    assign s_hash_hi = i_s_tdata[cbf_pkg::CMD_W + cbf_pkg::HALF_W +: cbf_pkg::HALF_W];

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_load   = (r_state == S_RESP) && (!r_m_tvalid || i_m_tready);

    // size in use: out-of-range settings fall back to the full table
    assign size_ok  = (r_table_size != '0) && (32'(r_table_size) <= 32'(NUM_COUNTERS));
    assign size_use = size_ok ? SIZE_W'(r_table_size) : SIZE_W'(NUM_COUNTERS);

    // remainder unit: upper half starts on acceptance, lower half follows
    assign mod_start    = (s_accept && (s_cmd != cbf_pkg::CMD_CLEAR))
                       || ((r_state == S_MOD_HI) && mod_done);
    assign mod_dividend = (r_state == S_IDLE) ? s_hash_hi : r_hash_lo;

    cbf_mod #(
        .SIZE_W (SIZE_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dividend),
        .i_divisor  (size_use),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign idx_eq = (r_idx1 == r_idx2);

    // RAM port steering: sweep, first write-back, second write-back
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx1;
        ram_wdata = r_new1;
        if (r_state == S_CLR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (r_state == S_WR1) begin
            ram_we    = r_wr;
        end else if (r_state == S_WR2) begin
            ram_we    = r_wr && !idx_eq;
            ram_waddr = r_idx2;
            ram_wdata = r_new2;
        end
    end
    assign ram_raddr = (r_state == S_RD1) ? r_idx1 : r_idx2;

    cbf_ram #(
        .WIDTH (COUNTER_BITS),
        .DEPTH (NUM_COUNTERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Counter evaluation, valid in S_RD_WAIT (second counter on the RAM output).
    // Equal indices: the one counter steps twice, written once.
    always_comb begin
        c1    = r_c1;
        c2    = ram_rdata;
        lt1   = CMP_W'(c1) < CMP_W'(r_fill_limit);
        lt2   = CMP_W'(c2) < CMP_W'(r_fill_limit);
        nz1   = (c1 != '0);
        nz2   = (c2 != '0);
        both  = nz1 && nz2;
        inc1  = (c1 == CNT_MAX) ? c1 : c1 + 1'b1;
        inc1b = (inc1 == CNT_MAX) ? inc1 : inc1 + 1'b1;
        inc2  = (c2 == CNT_MAX) ? c2 : c2 + 1'b1;
        dec1  = (c1 == '0) ? c1 : c1 - 1'b1;
        dec1b = (dec1 == '0) ? dec1 : dec1 - 1'b1;
        dec2  = (c2 == '0) ? c2 : c2 - 1'b1;
        hit_wide = (c1 > c2) ? CMP_W'(c1) : CMP_W'(c2);
        ev_ok   = 1'b0;
        ev_sna  = 1'b0;
        ev_wr   = 1'b0;
        ev_hit  = '0;
        ev_new1 = c1;
        ev_new2 = c2;
        unique case (r_cmd)
            cbf_pkg::CMD_ADD: begin
                ev_ok   = lt1 && lt2;
                ev_wr   = ev_ok;
                ev_new1 = idx_eq ? inc1b : inc1;
                ev_new2 = inc2;
            end
            cbf_pkg::CMD_REMOVE: begin
                ev_ok   = both;
                ev_wr   = ev_ok;
                ev_new1 = idx_eq ? dec1b : dec1;
                ev_new2 = dec2;
            end
            cbf_pkg::CMD_QUERY: begin
                ev_ok  = 1'b1;
                ev_sna = both || !lt1 || !lt2;
                if (both) begin
                    ev_hit = (hit_wide > HIT_MAX) ? HIT_MAX[cbf_pkg::HIT_W-1:0]
                                                  : hit_wide[cbf_pkg::HIT_W-1:0];
                end
            end
            cbf_pkg::CMD_CLEAR: begin
                ev_ok = 1'b1;
            end
            default: begin
                ev_ok = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                if (r_clr_addr == IDX_LAST) begin
                    n_state = r_clr_cmd ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    n_state = (s_cmd == cbf_pkg::CMD_CLEAR) ? S_CLR : S_MOD_HI;
                end
            end
            S_MOD_HI:  if (mod_done) n_state = S_MOD_LO;
            S_MOD_LO:  if (mod_done) n_state = S_RD1;
            S_RD1:     n_state = S_RD2;
            S_RD2:     n_state = S_RD_WAIT;
            S_RD_WAIT: n_state = S_WR1;
            S_WR1:     n_state = S_WR2;
            S_WR2:     n_state = S_RESP;
            S_RESP:    if (out_load) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_table_size <= cbf_pkg::TABLE_SIZE_RST;
            r_fill_limit <= cbf_pkg::FILL_LIMIT_RST;
            r_clr_addr   <= '0;
            r_clr_cmd    <= 1'b0;
            r_m_tvalid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wen) begin
                if (i_cfg_addr == cbf_pkg::CFG_TABLE_SIZE) begin
                    r_table_size <= i_cfg_wdata[cbf_pkg::TABLE_SIZE_W-1:0];
                end else if (i_cfg_addr == cbf_pkg::CFG_FILL_LIMIT) begin
                    r_fill_limit <= i_cfg_wdata[cbf_pkg::FILL_LIMIT_W-1:0];
                end
            end

            if (r_state == S_CLR) begin
                r_clr_addr <= (r_clr_addr == IDX_LAST) ? '0 : r_clr_addr + 1'b1;
            end

            if (s_accept) begin
                r_cmd     <= s_cmd;
                r_hash_lo <= s_hash_lo;
                r_clr_cmd <= (s_cmd == cbf_pkg::CMD_CLEAR);
                // clear result is fixed up front
                r_ok      <= 1'b1;
                r_sna     <= 1'b0;
                r_hit     <= '0;
                r_wr      <= 1'b0;
            end

            if ((r_state == S_MOD_HI) && mod_done) begin
                r_idx1 <= mod_rem[IDX_W-1:0];
            end
            if ((r_state == S_MOD_LO) && mod_done) begin
                r_idx2 <= mod_rem[IDX_W-1:0];
            end
            if (r_state == S_RD2) begin
                r_c1 <= ram_rdata;
            end
            if (r_state == S_RD_WAIT) begin
                r_ok   <= ev_ok;
                r_sna  <= ev_sna;
                r_hit  <= ev_hit;
                r_wr   <= ev_wr;
                r_new1 <= ev_new1;
                r_new2 <= ev_new2;
            end

            // output register: taken by the sink, reloaded from the sequencer
            if (out_load) begin
                r_m_tvalid <= 1'b1;
                r_m_tdata  <= {{(cbf_pkg::M_TDATA_W - cbf_pkg::M_FIELDS_W){1'b0}},
                               r_hit, r_sna, r_ok};
            end else if (r_m_tvalid && i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

`ifndef ASSERT_OFF
    // one transaction at a time: ready drops right after acceptance
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_tready)
        else $error("input accepted while a transaction is in flight");

    // the remainder unit only finishes while the sequencer waits for it
    a_mod_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> ((r_state == S_MOD_HI) || (r_state == S_MOD_LO)))
        else $error("remainder finished outside a modulo state");

    // write-backs land inside the table size in use
    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ((r_state == S_WR1) || (r_state == S_WR2)))
            |-> ((SIZE_W + 1)'(ram_waddr) < (SIZE_W + 1)'(size_use)))
        else $error("counter write beyond table size");

    // a result is never loaded over one the sink has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_tvalid && !i_m_tready && (r_state == S_RESP)) |=> (r_state == S_RESP))
        else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

/* sv/cbf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* sv/cbf_mod.sv */
// Iterative remainder unit: 32-bit dividend modulo a small divisor,
// MOD_STEPS restoring steps per cycle. Depends on cbf_pkg.
`default_nettype none

module cbf_mod #(
    parameter int SIZE_W = 11
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [cbf_pkg::HALF_W-1:0]  i_dividend,
    input  wire logic [SIZE_W-1:0]           i_divisor,
    output logic                             o_done,
    output logic      [SIZE_W-1:0]           o_rem
);

    localparam int CNT_W = (cbf_pkg::MOD_CYCLES > 1) ? $clog2(cbf_pkg::MOD_CYCLES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(cbf_pkg::MOD_CYCLES - 1);

    logic                        r_busy;
    logic [CNT_W-1:0]            r_cnt;
    logic [cbf_pkg::HALF_W-1:0]  r_dvd;
    logic [SIZE_W-1:0]           r_rem;
    logic [SIZE_W-1:0]           r_div;
    logic [cbf_pkg::HALF_W-1:0]  n_dvd;
    logic [SIZE_W-1:0]           n_rem;
    logic [SIZE_W:0]             trial;

    // Remainder stays below the divisor, so each trial is below twice it
    always_comb begin
        n_rem = r_rem;
        n_dvd = r_dvd;
        trial = '0;
        for (int k = 0; k < cbf_pkg::MOD_STEPS; k++) begin
            trial = {n_rem, n_dvd[cbf_pkg::HALF_W-1]};
            n_dvd = {n_dvd[cbf_pkg::HALF_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                trial = trial - {1'b0, r_div};
            end
            n_rem = trial[SIZE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_dvd <= n_dvd;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_rem = r_rem;

endmodule

`default_nettype wire
